// ===== src/assert_macros.svh =====
// Assertion macros used by the checker module.
// Depends on nothing; pulled in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/isort_pkg.sv =====
// Shared types and constants of the insertion sort engine.
// Depends on nothing; used by the engine top level, the checker and the testbench.
package isort_pkg;

  localparam int DEPTH   = 64;
  localparam int DATA_W  = 32;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last_item;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     last_out;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_PLACE,
    ST_EMIT
  } state_t;

endpackage

// ===== src/isort_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module isort_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/insertion_sort_engine.sv =====
// Insertion sort engine: top level with the insertion and emission sequencer.
// Depends on isort_pkg and isort_ram.
//
// Each beat accepted on start (while busy is low) is inserted into a sorted
// store held in one RAM, shifting larger entries up one place per clock.
// An item on an empty store is written directly, with no insertion steps; on a
// store of c entries it keeps busy high while each larger entry is shifted
// up and then for the final write, bounded by the single RAM write port
// doing one shift per cycle. On an item marked last, or the one that fills
// all DEPTH entries, the set of n values is read out one per cycle:
// out_valid marks n consecutive beats, the first one after the EMIT state
// and the registered RAM read, with last_out on the final beat. The
// receiver cannot stall the output; busy falls in the cycle of the final
// beat and a new set may begin then.
module insertion_sort_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  isort_pkg::in_item_t  in_data,
  output logic                out_valid,
  output isort_pkg::out_item_t out_data
);

  isort_pkg::state_t state_r, state_nxt;
  isort_pkg::cnt_t   cnt_r, cnt_nxt;
  isort_pkg::idx_t   j_r, j_nxt;
  isort_pkg::idx_t   k_r, k_nxt;
  logic signed [isort_pkg::DATA_W-1:0] val_r, val_nxt;
  logic              emit_v_r, emit_v_nxt;
  logic              emit_last_r, emit_last_nxt;

  // hold the last mark of the beat under insertion
  logic              last_hold_r;

  logic                          we;
  isort_pkg::idx_t               waddr;
  logic [isort_pkg::DATA_W-1:0]  wdata;
  isort_pkg::idx_t               raddr;
  logic [isort_pkg::DATA_W-1:0]  rdata;
  logic                          fin;
  logic                          fin_last;
  isort_pkg::cnt_t               cnt_inc;

  isort_ram #(
    .WIDTH (isort_pkg::DATA_W),
    .DEPTH (isort_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign cnt_inc = cnt_r + isort_pkg::CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= isort_pkg::ST_IDLE;
      cnt_r       <= '0;
      emit_v_r    <= 1'b0;
      emit_last_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      emit_v_r    <= emit_v_nxt;
      emit_last_r <= emit_last_nxt;
    end
    j_r   <= j_nxt;
    k_r   <= k_nxt;
    val_r <= val_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    val_nxt       = val_r;
    emit_v_nxt    = 1'b0;
    emit_last_nxt = 1'b0;
    we            = 1'b0;
    waddr         = j_r;
    wdata         = val_r;
    raddr         = j_r - isort_pkg::IDX_W'(1);
    fin           = 1'b0;
    fin_last      = 1'b0;

    unique case (state_r)
      isort_pkg::ST_IDLE: begin
        if (start) begin
          val_nxt = in_data.value;
          if (cnt_r == '0) begin
            we       = 1'b1;
            waddr    = '0;
            wdata    = in_data.value;
            fin      = 1'b1;
            fin_last = in_data.last_item;
          end else begin
            j_nxt     = cnt_r[isort_pkg::IDX_W-1:0];
            raddr     = cnt_r[isort_pkg::IDX_W-1:0] - isort_pkg::IDX_W'(1);
            state_nxt = isort_pkg::ST_CMP;
          end
        end
      end
      isort_pkg::ST_CMP: begin
        if ($signed(rdata) > val_r) begin
          we    = 1'b1;
          wdata = rdata;
          j_nxt = j_r - isort_pkg::IDX_W'(1);
          raddr = j_r - isort_pkg::IDX_W'(2);
          if (j_r == isort_pkg::IDX_W'(1)) begin
            state_nxt = isort_pkg::ST_PLACE;
          end
        end else begin
          we       = 1'b1;
          fin      = 1'b1;
          fin_last = last_hold_r;
        end
      end
      isort_pkg::ST_PLACE: begin
        we       = 1'b1;
        waddr    = '0;
        fin      = 1'b1;
        fin_last = last_hold_r;
      end
      isort_pkg::ST_EMIT: begin
        raddr         = k_r;
        k_nxt         = k_r + isort_pkg::IDX_W'(1);
        emit_v_nxt    = 1'b1;
        emit_last_nxt = ({1'b0, k_r} + isort_pkg::CNT_W'(1)) == cnt_r;
        if (emit_last_nxt) begin
          cnt_nxt   = '0;
          state_nxt = isort_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = isort_pkg::ST_IDLE;
      end
    endcase

    if (fin) begin
      cnt_nxt = cnt_inc;
      k_nxt   = '0;
      if (fin_last || cnt_inc == isort_pkg::CNT_W'(isort_pkg::DEPTH)) begin
        state_nxt = isort_pkg::ST_EMIT;
      end else begin
        state_nxt = isort_pkg::ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      last_hold_r <= in_data.last_item;
    end
  end

  assign busy                  = state_r != isort_pkg::ST_IDLE;
  assign out_valid             = emit_v_r;
  assign out_data.sorted_value = $signed(rdata);
  assign out_data.last_out     = emit_last_r;

endmodule

// ===== src/isort_chk.sv =====
// Port-level checker for the insertion sort engine, bound to the top level.
// Depends on isort_pkg and assert_macros.svh.
`include "assert_macros.svh"

module isort_chk (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 busy,
  input logic                 out_valid,
  input isort_pkg::out_item_t out_data
);

  `ASSERT_NEXT(a_emit_contig, clk, rst_n,
               out_valid && !out_data.last_out, out_valid, "gap inside a sorted set")
  `ASSERT_SAME(a_emit_busy, clk, rst_n,
               out_valid && !out_data.last_out, busy, "busy low mid set")
  `ASSERT_NEXT(a_emit_end, clk, rst_n,
               out_valid && out_data.last_out, !out_valid, "beat after last")
  `ASSERT_NEXT(a_emit_order, clk, rst_n, out_valid && !out_data.last_out,
               $signed(out_data.sorted_value) >= $signed($past(out_data.sorted_value)),
               "set out of order")

endmodule

bind insertion_sort_engine isort_chk u_isort_chk (.*);

// ===== tb/tb_top.sv =====
// Self-checking testbench for insertion_sort_engine: drives sets of signed values,
// predicts the sorted beats and checks every output beat in order.
// Depends on isort_pkg and the insertion_sort_engine RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 3000;
  localparam int NUM_ITEMS   = 380;
  localparam int REPORT_MAX  = 10;

  class sorted_set_tracker;
    logic signed [isort_pkg::DATA_W-1:0] held[isort_pkg::DEPTH];
    int unsigned held_count;
    isort_pkg::out_item_t due_beats[$];
    int unsigned mismatches;
    int unsigned sets_done;
    int unsigned full_sets;
    int unsigned items_seen;
    int unsigned beats_checked;

    function new();
      held_count = 0;
      mismatches = 0;
      sets_done = 0;
      full_sets = 0;
      items_seen = 0;
      beats_checked = 0;
    endfunction

    function void note_item(isort_pkg::in_item_t item);
      int j;
      isort_pkg::out_item_t beat;
      j = held_count;
      if (j >= isort_pkg::DEPTH) j = isort_pkg::DEPTH - 1;
      while (j > 0 && held[j-1] > item.value) begin
        held[j] = held[j-1];
        j--;
      end
      held[j] = item.value;
      if (held_count < isort_pkg::DEPTH) held_count++;
      items_seen++;
      if (item.last_item || held_count == isort_pkg::DEPTH) begin
        for (int k = 0; k < held_count; k++) begin
          beat.sorted_value = held[k];
          beat.last_out = (k + 1 == held_count);
          due_beats.push_back(beat);
        end
        if (!item.last_item) full_sets++;
        sets_done++;
        held_count = 0;
      end
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= REPORT_MAX) $display("%0t: %s", $realtime, msg);
    endfunction

    function void check_beat(isort_pkg::out_item_t got);
      isort_pkg::out_item_t want;
      if (due_beats.size() == 0) begin
        flag($sformatf("unexpected beat: value %0d last %0b", got.sorted_value,
                       got.last_out));
        return;
      end
      want = due_beats.pop_front();
      beats_checked++;
      if (got.sorted_value !== want.sorted_value)
        flag($sformatf("sorted_value: expected %0d, got %0d", want.sorted_value,
                       got.sorted_value));
      if (got.last_out !== want.last_out)
        flag($sformatf("last_out: expected %0b, got %0b (value %0d)", want.last_out,
                       got.last_out, want.sorted_value));
    endfunction

    function int pending();
      return due_beats.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  isort_pkg::in_item_t  in_data;
  logic                 out_valid;
  isort_pkg::out_item_t out_data;

  sorted_set_tracker tracker;
  int unsigned quiet_cycles;
  int unsigned items_sent;
  bit          no_idle;

  insertion_sort_engine DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) tracker.note_item(in_data);
      if (out_valid) tracker.check_beat(out_data);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no activity for %0d cycles", QUIET_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [isort_pkg::DATA_W-1:0] pick_value(int mode);
    logic signed [isort_pkg::DATA_W-1:0] v;
    case (mode)
      1: v = $signed($urandom_range(0, 8)) - 4;
      2: begin
        case ($urandom_range(0, 4))
          0: v = 32'sh7fffffff;
          1: v = 32'sh80000000;
          2: v = 0;
          3: v = -1;
          default: v = 1;
        endcase
      end
      3: v = 32'sh7fffffe0 + $urandom_range(0, 63);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic send_item(input logic signed [isort_pkg::DATA_W-1:0] v, input logic lst);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    start <= 1'b1;
    in_data <= '{value: v, last_item: lst};
    do @(posedge clk); while (busy);
    items_sent++;
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      in_data <= '{value: $urandom, last_item: 1'($urandom_range(0, 1))};
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic send_set(input int size, input logic mark_end, input int mode);
    for (int i = 0; i < size; i++)
      send_item(pick_value(mode), (i == size - 1) ? mark_end : 1'b0);
  endtask

  initial begin
    int size;
    int set_idx;
    logic mark_end;
    tracker = new();
    items_sent = 0;
    no_idle = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_item(32'sh7fffffff, 1'b1);
    send_item(32'sh80000000, 1'b1);
    send_item(32'sh7fffffff, 1'b0);
    send_item(32'sh80000000, 1'b0);
    send_item(0, 1'b0);
    send_item(-1, 1'b0);
    send_item(1, 1'b1);
    send_item(5, 1'b0);
    send_item(5, 1'b0);
    send_item(-5, 1'b0);
    send_item(5, 1'b0);
    send_item(-5, 1'b1);
    send_item(3, 1'b0);
    send_item(2, 1'b0);
    send_item(1, 1'b0);
    send_item(0, 1'b1);
    send_item(-2, 1'b0);
    send_item(-1, 1'b1);
    send_item(32'sh55555555, 1'b0);
    send_item(32'shaaaaaaaa, 1'b1);
    drain_results();

    set_idx = 0;
    while (items_sent < NUM_ITEMS) begin
      no_idle = ($urandom_range(0, 3) == 0);
      mark_end = 1'b1;
      if (set_idx == 0) begin
        size = isort_pkg::DEPTH;
        mark_end = 1'b0;
      end else if (set_idx == 1) begin
        size = isort_pkg::DEPTH;
      end else begin
        case ($urandom_range(0, 9))
          0: begin
            size = isort_pkg::DEPTH;
            mark_end = 1'($urandom_range(0, 1));
          end
          1, 2: size = $urandom_range(11, 40);
          default: size = $urandom_range(1, 10);
        endcase
      end
      if (size > NUM_ITEMS - items_sent) begin
        size = NUM_ITEMS - items_sent;
        mark_end = 1'b1;
      end
      if ($urandom_range(0, 9) == 0) drain_results();
      send_set(size, mark_end, ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 3));
      set_idx++;
    end

    @(negedge clk);
    start <= 1'b0;
    drain_results();
    repeat (20) @(posedge clk);

    $display("Sent %0d values in %0d sets, %0d of them closed by a full store;",
             tracker.items_seen, tracker.sets_done, tracker.full_sets);
    $display("checked %0d sorted beats, %0d mismatches.", tracker.beats_checked,
             tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      if (tracker.pending() != 0)
        $display("%0d expected beats never arrived", tracker.pending());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/isort_pkg.sv
src/isort_ram.sv
src/insertion_sort_engine.sv
src/isort_chk.sv
tb/tb_top.sv
